### hdl/pcacc_pkg.sv
// Package for the patch covariance accumulator: payload structs, codes, sizes.
// No dependencies.
package pcacc_pkg;

   localparam int MAX_DIM = 16;
   localparam int MAX_LOCATIONS = 256;
   localparam int DIM_W = $clog2(MAX_DIM);
   localparam int LOC_W = $clog2(MAX_LOCATIONS);
   localparam int SUM_AW = LOC_W + DIM_W;
   localparam int MOM_AW = LOC_W + 2 * DIM_W;
   localparam logic signed [47:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] ACC_MIN = 48'sh8000_0000_0000;

   localparam logic [2:0] ACT_ADD = 3'd0;
   localparam logic [2:0] ACT_RD_SUM = 3'd1;
   localparam logic [2:0] ACT_RD_MOM = 3'd2;
   localparam logic [2:0] ACT_RD_CNT = 3'd3;
   localparam logic [2:0] ACT_CLEAR = 3'd4;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_COUNT = 2'd1;
   localparam logic [1:0] ST_LOC = 2'd2;
   localparam logic [1:0] ST_INDEX = 2'd3;

   localparam logic CSR_DIM = 1'b0;
   localparam logic CSR_LOCS = 1'b1;

   typedef struct packed {
      logic [2:0]         action;
      logic [7:0]         location;
      logic signed [15:0] element_value;
      logic               last_element;
      logic [3:0]         row_index;
      logic [3:0]         column_index;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [47:0] read_value;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_NONE, OP_ACCUM, OP_RD_SUM, OP_RD_MOM, OP_RD_CNT, OP_CLEAR, OP_STATUS
   } op_type;

   // Classified work handed from front to back.
   typedef struct packed {
      op_type       op;
      logic [1:0]   status;
      logic [LOC_W-1:0] loc;
      logic [DIM_W-1:0] row;
      logic [DIM_W-1:0] col;
      logic [DIM_W:0]   dim;
      logic         bump;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE, BK_CLEAR, BK_RD, BK_RD_WAIT, BK_MAC, BK_MAC_WR, BK_OUT
   } bk_state_type;

endpackage

### hdl/patch_covariance_accumulator_top.sv
// Top level of the patch covariance accumulator: registers, front, queue, back.
// Depends on pcacc_pkg, pcacc_front, pcacc_queue, pcacc_back.
//
//  channel | direction | handshake        | payload
//  req_    | in        | valid / stall    | pcacc_pkg::req_type
//  rsp_    | out       | valid / stall    | pcacc_pkg::rsp_type
//  csr_    | in        | valid / ready    | index, write data
//
// Element adds fill the front buffer; after the last element of a good patch, adds stall
// until its update is done. A completed patch is applied with one moment read-modify-write
// per entry through a single port (BK_MAC, then BK_MAC_WR), D*D entries for D = dimension.
// Reads pass BK_RD, BK_RD_WAIT; clear zeroes sums, all 65536 moment entries and the count.
// Reset starts the same clearing pass; no item is taken until it ends.
// A stalled result is held in the output register while the front fills the queue.
module patch_covariance_accumulator_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  pcacc_pkg::req_type   req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pcacc_pkg::rsp_type   rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_index,
   input  logic [8:0]           csr_wdata
);
   logic [4:0] dim_ff;
   logic [8:0] locs_ff;
   logic q_full, q_push, q_pop, q_ne, mac_done, boot_ff, front_stall, bk_rsp_valid;
   pcacc_pkg::cmd_type push_cmd, head;
   logic [pcacc_pkg::DIM_W-1:0] a1, a2;
   logic signed [15:0] d1, d2;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff <= 5'd16; locs_ff <= 9'd256; boot_ff <= 1'b1;
      end else begin
         if (csr_valid && csr_index == pcacc_pkg::CSR_DIM) dim_ff <= csr_wdata[4:0];
         if (csr_valid && csr_index == pcacc_pkg::CSR_LOCS) locs_ff <= csr_wdata;
         if (bk_rsp_valid) boot_ff <= 1'b0;
      end
   end

   // The reset clearing pass emits one internal result: drop it.
   assign rsp_valid = bk_rsp_valid && !boot_ff;
   assign req_stall = front_stall || boot_ff;

   pcacc_front u_front (
      .clock, .reset, .req_valid(req_valid && !boot_ff), .req_stall(front_stall), .req_data,
      .dim_cfg(dim_ff), .locs_cfg(locs_ff), .q_full, .q_push, .q_cmd(push_cmd),
      .mac_done, .buf_rd_addr(a1), .buf_rd_data(d1), .buf_rd_addr2(a2), .buf_rd_data2(d2)
   );

   pcacc_queue u_queue (
      .clock, .reset, .push(q_push), .push_cmd, .full(q_full),
      .pop(q_pop), .not_empty(q_ne), .head
   );

   pcacc_back u_back (
      .clock, .reset, .q_valid(q_ne), .q_cmd(head), .q_pop, .mac_done,
      .buf_rd_addr(a1), .buf_rd_data(d1), .buf_rd_addr2(a2), .buf_rd_data2(d2),
      .rsp_valid(bk_rsp_valid), .rsp_stall(rsp_stall && !boot_ff), .rsp_data
   );
endmodule

### hdl/pcacc_front.sv
// Front end: buffers patch elements, checks ranges and counts, issues commands.
// Depends on pcacc_pkg.
module pcacc_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  pcacc_pkg::req_type             req_data,
   input  logic [4:0]                     dim_cfg,
   input  logic [8:0]                     locs_cfg,
   input  logic                           q_full,
   output logic                           q_push,
   output pcacc_pkg::cmd_type             q_cmd,
   input  logic                           mac_done,
   input  logic [pcacc_pkg::DIM_W-1:0]    buf_rd_addr,
   output logic signed [15:0]             buf_rd_data,
   input  logic [pcacc_pkg::DIM_W-1:0]    buf_rd_addr2,
   output logic signed [15:0]             buf_rd_data2
);
   logic signed [15:0] buf_mem [pcacc_pkg::MAX_DIM];
   logic [pcacc_pkg::DIM_W:0] count_ff, count_in;
   logic [pcacc_pkg::DIM_W:0] dim_eff;
   logic [9:0] locs_eff;
   logic accept, loc_bad, is_add;
   logic pend_ff, pend_in;

   always_comb begin
      if (dim_cfg == 5'd0) dim_eff = (pcacc_pkg::DIM_W+1)'(1);
      else if (dim_cfg > 5'(pcacc_pkg::MAX_DIM))
         dim_eff = (pcacc_pkg::DIM_W+1)'(pcacc_pkg::MAX_DIM);
      else dim_eff = (pcacc_pkg::DIM_W+1)'(dim_cfg);
      if (locs_cfg == 9'd0) locs_eff = 10'd1;
      else if (locs_cfg > 9'(pcacc_pkg::MAX_LOCATIONS))
         locs_eff = 10'(pcacc_pkg::MAX_LOCATIONS);
      else locs_eff = {1'b0, locs_cfg};
   end

   // The buffer is shared with the back end: hold adds from the push of a
   // completed good patch until the back end has finished multiplying it.
   assign is_add = req_data.action == pcacc_pkg::ACT_ADD;
   assign req_stall = q_full || (is_add && pend_ff);
   assign accept = req_valid && !req_stall;
   assign loc_bad = {2'b0, req_data.location} >= locs_eff;

   always_comb begin
      count_in = count_ff;
      pend_in = pend_ff && !mac_done;
      q_push = 1'b0;
      q_cmd.op = pcacc_pkg::OP_NONE;
      q_cmd.status = pcacc_pkg::ST_OK;
      q_cmd.loc = req_data.location;
      q_cmd.row = req_data.row_index;
      q_cmd.col = req_data.column_index;
      q_cmd.dim = dim_eff;
      q_cmd.bump = {2'b0, req_data.location} == locs_eff - 10'd1;
      if (accept) begin
         unique case (req_data.action) inside
            pcacc_pkg::ACT_ADD: begin
               if (count_ff < (pcacc_pkg::DIM_W+1)'(pcacc_pkg::MAX_DIM))
                  count_in = count_ff + 1'b1;
               else count_in = (pcacc_pkg::DIM_W+1)'(pcacc_pkg::MAX_DIM + 1);
               if (req_data.last_element) begin
                  q_push = 1'b1;
                  if (loc_bad) begin
                     q_cmd.op = pcacc_pkg::OP_STATUS; q_cmd.status = pcacc_pkg::ST_LOC;
                  end else if (count_in != dim_eff) begin
                     q_cmd.op = pcacc_pkg::OP_STATUS; q_cmd.status = pcacc_pkg::ST_COUNT;
                  end else begin
                     q_cmd.op = pcacc_pkg::OP_ACCUM; pend_in = 1'b1;
                  end
                  count_in = '0;
               end
            end
            pcacc_pkg::ACT_RD_SUM, pcacc_pkg::ACT_RD_MOM: begin
               q_push = 1'b1;
               if (loc_bad) begin
                  q_cmd.op = pcacc_pkg::OP_STATUS; q_cmd.status = pcacc_pkg::ST_LOC;
               end else if ({1'b0, req_data.row_index} >= dim_eff ||
                  (req_data.action == pcacc_pkg::ACT_RD_MOM &&
                   {1'b0, req_data.column_index} >= dim_eff)) begin
                  q_cmd.op = pcacc_pkg::OP_STATUS; q_cmd.status = pcacc_pkg::ST_INDEX;
               end else if (req_data.action == pcacc_pkg::ACT_RD_SUM)
                  q_cmd.op = pcacc_pkg::OP_RD_SUM;
               else q_cmd.op = pcacc_pkg::OP_RD_MOM;
            end
            pcacc_pkg::ACT_RD_CNT: begin
               q_push = 1'b1; q_cmd.op = pcacc_pkg::OP_RD_CNT;
            end
            pcacc_pkg::ACT_CLEAR: begin
               q_push = 1'b1; q_cmd.op = pcacc_pkg::OP_CLEAR; count_in = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0; pend_ff <= 1'b0;
      end else begin
         count_ff <= count_in; pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && is_add && count_ff < (pcacc_pkg::DIM_W+1)'(pcacc_pkg::MAX_DIM))
         buf_mem[count_ff[pcacc_pkg::DIM_W-1:0]] <= req_data.element_value;
   end

   assign buf_rd_data = buf_mem[buf_rd_addr];
   assign buf_rd_data2 = buf_mem[buf_rd_addr2];
endmodule

### hdl/pcacc_queue.sv
// Short command queue between front and back ends.
// Depends on pcacc_pkg.
module pcacc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  pcacc_pkg::cmd_type  push_cmd,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output pcacc_pkg::cmd_type  head
);
   pcacc_pkg::cmd_type slot_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic rd_ff, wr_ff;

   assign full = cnt_ff == 2'd2;
   assign not_empty = cnt_ff != 2'd0;
   assign head = slot_ff[rd_ff];
   assign cnt_in = cnt_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0; rd_ff <= 1'b0; wr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wr_ff <= !wr_ff;
         if (pop) rd_ff <= !rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_cmd;
   end
endmodule

### hdl/pcacc_back.sv
// Back end: clearing pass, saturating sum and moment updates, reads, result register.
// Depends on pcacc_pkg.
module pcacc_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_valid,
   input  pcacc_pkg::cmd_type             q_cmd,
   output logic                           q_pop,
   output logic                           mac_done,
   output logic [pcacc_pkg::DIM_W-1:0]    buf_rd_addr,
   input  logic signed [15:0]             buf_rd_data,
   output logic [pcacc_pkg::DIM_W-1:0]    buf_rd_addr2,
   input  logic signed [15:0]             buf_rd_data2,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output pcacc_pkg::rsp_type             rsp_data
);
   logic signed [47:0] sum_mem [1 << pcacc_pkg::SUM_AW];
   logic signed [47:0] mom_mem [1 << pcacc_pkg::MOM_AW];

   pcacc_pkg::bk_state_type state_ff, state_in;
   pcacc_pkg::cmd_type cmd_ff, cmd_in;
   logic [pcacc_pkg::MOM_AW-1:0] clr_ff, clr_in;
   logic [pcacc_pkg::DIM_W-1:0] r_ff, r_in, c_ff, c_in;
   logic [31:0] samples_ff, samples_in;
   logic rsp_valid_ff, rsp_valid_in;
   pcacc_pkg::rsp_type rsp_ff, rsp_in;
   logic signed [47:0] sum_rd_ff, mom_rd_ff;
   logic signed [31:0] prod_ff;
   logic signed [15:0] xr_ff;
   logic [pcacc_pkg::SUM_AW-1:0] sum_addr;
   logic [pcacc_pkg::MOM_AW-1:0] mom_addr;
   logic sum_we, mom_we;
   logic signed [47:0] sum_wd, mom_wd;
   logic last_r, last_c;

   function automatic logic signed [47:0] sat_add(logic signed [47:0] a, logic signed [31:0] b);
      logic signed [48:0] s;
      s = 49'(a) + 49'(b);
      if (s > 49'(pcacc_pkg::ACC_MAX)) return pcacc_pkg::ACC_MAX;
      if (s < 49'(pcacc_pkg::ACC_MIN)) return pcacc_pkg::ACC_MIN;
      return s[47:0];
   endfunction

   assign last_r = {1'b0, r_ff} == cmd_ff.dim - 1'b1;
   assign last_c = {1'b0, c_ff} == cmd_ff.dim - 1'b1;
   assign buf_rd_addr = r_ff;
   assign buf_rd_addr2 = c_ff;
   assign mac_done = state_ff == pcacc_pkg::BK_MAC_WR && last_c && last_r;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      state_in = state_ff; cmd_in = cmd_ff; clr_in = clr_ff;
      r_in = r_ff; c_in = c_ff; samples_in = samples_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall; rsp_in = rsp_ff;
      q_pop = 1'b0;
      sum_addr = {cmd_ff.loc, r_ff};
      mom_addr = {cmd_ff.loc, r_ff, c_ff};
      sum_we = 1'b0; mom_we = 1'b0;
      sum_wd = sat_add(sum_rd_ff, 32'(xr_ff));
      mom_wd = sat_add(mom_rd_ff, prod_ff);
      unique case (state_ff)
         pcacc_pkg::BK_CLEAR: begin
            sum_addr = clr_ff[pcacc_pkg::SUM_AW-1:0]; mom_addr = clr_ff;
            sum_we = 1'b1; mom_we = 1'b1; sum_wd = '0; mom_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (&clr_ff) state_in = pcacc_pkg::BK_OUT;
         end
         pcacc_pkg::BK_IDLE: begin
            if (q_valid && !rsp_valid_in) begin
               q_pop = 1'b1; cmd_in = q_cmd;
               r_in = '0; c_in = '0;
               rsp_in.status = q_cmd.status; rsp_in.read_value = '0;
               unique case (q_cmd.op) inside
                  pcacc_pkg::OP_ACCUM: state_in = pcacc_pkg::BK_MAC;
                  pcacc_pkg::OP_RD_SUM, pcacc_pkg::OP_RD_MOM: begin
                     r_in = q_cmd.row; c_in = q_cmd.col; state_in = pcacc_pkg::BK_RD;
                  end
                  pcacc_pkg::OP_RD_CNT: begin
                     rsp_in.read_value = 48'(samples_ff); state_in = pcacc_pkg::BK_OUT;
                  end
                  pcacc_pkg::OP_CLEAR: begin
                     samples_in = '0; clr_in = '0; state_in = pcacc_pkg::BK_CLEAR;
                  end
                  default: state_in = pcacc_pkg::BK_OUT;
               endcase
            end
         end
         pcacc_pkg::BK_RD: state_in = pcacc_pkg::BK_RD_WAIT;
         pcacc_pkg::BK_RD_WAIT: begin
            rsp_in.read_value = (cmd_ff.op == pcacc_pkg::OP_RD_SUM) ? sum_rd_ff : mom_rd_ff;
            state_in = pcacc_pkg::BK_OUT;
         end
         // Read the entries and form the product; write back in BK_MAC_WR.
         pcacc_pkg::BK_MAC: state_in = pcacc_pkg::BK_MAC_WR;
         pcacc_pkg::BK_MAC_WR: begin
            mom_we = 1'b1;
            sum_we = c_ff == '0;
            state_in = pcacc_pkg::BK_MAC;
            if (last_c) begin
               c_in = '0; r_in = r_ff + 1'b1;
               if (last_r) begin
                  state_in = pcacc_pkg::BK_OUT;
                  if (cmd_ff.bump && samples_ff != 32'hFFFF_FFFF)
                     samples_in = samples_ff + 1'b1;
               end
            end else c_in = c_ff + 1'b1;
         end
         pcacc_pkg::BK_OUT: begin
            if (!rsp_valid_in) begin
               rsp_valid_in = 1'b1; state_in = pcacc_pkg::BK_IDLE;
            end
         end
         default: state_in = pcacc_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcacc_pkg::BK_CLEAR; clr_ff <= '0; samples_ff <= '0;
         rsp_valid_ff <= 1'b0; r_ff <= '0; c_ff <= '0;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in; samples_ff <= samples_in;
         rsp_valid_ff <= rsp_valid_in; r_ff <= r_in; c_ff <= c_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      rsp_ff <= rsp_in;
      xr_ff <= buf_rd_data;
      prod_ff <= buf_rd_data * buf_rd_data2;
   end

   always_ff @(posedge clock) begin
      if (sum_we) sum_mem[sum_addr] <= sum_wd;
      sum_rd_ff <= sum_mem[sum_addr];
   end

   always_ff @(posedge clock) begin
      if (mom_we) mom_mem[mom_addr] <= mom_wd;
      mom_rd_ff <= mom_mem[mom_addr];
   end
endmodule
